[sv/dfl_pkg.sv]
// Shared types and constants for the descriptor free-list allocator.
// No dependencies.
`timescale 1ns / 1ps

package dfl_pkg;

	localparam int RINGS_DEF = 4;
	localparam int DESCS_DEF = 256;

	localparam int FUNC_W = 3;
	localparam int RING_W = 2;
	localparam int DIDX_W = 8;
	localparam int AMT_W  = 9;
	localparam int LINK_W = 16;
	localparam int STAT_W = 2;

	localparam logic [LINK_W-1:0] END_MARK = 16'hffff;

	typedef enum logic [FUNC_W-1:0] {
		FN_INIT  = 3'd0,
		FN_ALLOC = 3'd1,
		FN_CHAIN = 3'd2,
		FN_FREE  = 3'd3,
		FN_READ  = 3'd4
	} func_t;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;

endpackage

[sv/descriptor_free_list_allocator.sv]
// Descriptor free-list allocator: per-ring LIFO free lists threaded through
// link and chained-flag RAMs. Depends on dfl_pkg and dfl_ram.
`timescale 1ns / 1ps

// A command is taken at a clock edge where start is high and busy is low; the
// result is registered on the result ports when the command finishes, marked
// by done for exactly one cycle. There is no backpressure on the result
// side: done is a plain strobe and the receiver must take it. Free, error
// cases and empty/short rings finish at the accepting edge and busy never
// rises, so such commands can be issued every cycle. Allocate-one and
// read-link go through one more state (ST_POP or ST_READ) for one RAM read.
// Chain allocation of N descriptors passes through ST_POP once per descriptor
// and ring init of length L through ST_INIT once per entry: both walk the
// link RAM one descriptor per cycle, which is what sets their rate. A chain
// pop writes the descriptor it read in the cycle that also reads the next
// head; when both hit the same entry the written link is forwarded. Per-ring
// head, free count and length live in flops; links and chained flags live in
// two RAMs with no reset: a link is only defined after init, free or chain
// allocation has written it.
module descriptor_free_list_allocator #(
	parameter int RINGS = dfl_pkg::RINGS_DEF,
	parameter int DESCS = dfl_pkg::DESCS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [dfl_pkg::FUNC_W-1:0]   func,
	input  logic [dfl_pkg::RING_W-1:0]   ring_sel,
	input  logic [dfl_pkg::DIDX_W-1:0]   desc_sel,
	input  logic [dfl_pkg::AMT_W-1:0]    amount,
	output logic                         done,
	output logic [dfl_pkg::STAT_W-1:0]   status,
	output logic [dfl_pkg::LINK_W-1:0]   got_index,
	output logic [dfl_pkg::LINK_W-1:0]   link_value,
	output logic                         link_chained,
	output logic [dfl_pkg::AMT_W-1:0]    free_left
);

	localparam int RW    = (RINGS > 1) ? $clog2(RINGS) : 1;
	localparam int DEPTH = RINGS * DESCS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = dfl_pkg::LINK_W;
	localparam int NW    = dfl_pkg::AMT_W;
	localparam int DW    = dfl_pkg::DIDX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_POP,
		ST_READ
	} state_t;

	state_t state_q;

	// per-ring control state
	logic [LW-1:0] head_q [RINGS];
	logic [NW-1:0] free_q [RINGS];
	logic [NW-1:0] len_q  [RINGS];

	// command context
	logic [RW-1:0] ring_q;
	logic [DW-1:0] cur_q;       // descriptor whose link is being read
	logic [DW-1:0] prev_q;      // previously popped descriptor of a chain
	logic          prev_v_q;
	logic          chain_q;     // chain allocation, links get rewritten
	logic [NW-1:0] cnt_q;       // pops left, or init length
	logic [NW-1:0] idx_q;       // init walk position
	logic          fwd_q;
	logic [LW-1:0] fwd_link_q;

	// result registers
	logic          done_q;
	logic [1:0]    status_q;
	logic [LW-1:0] got_q;
	logic [LW-1:0] lval_q;
	logic          lch_q;
	logic [NW-1:0] free_out_q;

	// RAM ports
	logic          link_we, ch_we, mem_re;
	logic [AW-1:0] waddr, raddr;
	logic [LW-1:0] link_wd, link_rd;
	logic          ch_wd, ch_rd;

	logic          acc;
	logic          ring_ok;
	logic [RW-1:0] ridx_in, rsel;
	logic [LW-1:0] head_r;
	logic [NW-1:0] free_r, len_r;
	logic          amt_bad;
	logic [LW-1:0] pop_link;
	logic [NW-1:0] pop_free;
	logic [LW-1:0] chain_wlink;

	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [DW-1:0] d);
		addr_of = AW'(r) * AW'(DESCS) + AW'(d);
	endfunction

	assign acc     = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign ring_ok = (32'(ring_sel) < RINGS);
	assign ridx_in = RW'(ring_sel);
	assign rsel    = (state_q == ST_IDLE) ? ridx_in : ring_q;
	assign head_r  = head_q[rsel];
	assign free_r  = free_q[rsel];
	assign len_r   = len_q[rsel];
	assign amt_bad = (amount == '0) || ((amount & (amount - NW'(1))) != '0)
		|| (32'(amount) > DESCS);

	// link of the descriptor being popped; forwarded when it was just rewritten
	assign pop_link    = fwd_q ? fwd_link_q : link_rd;
	assign pop_free    = free_q[ring_q] - NW'(1);
	assign chain_wlink = prev_v_q ? LW'(prev_q) : '0;

	// RAM control
	always_comb begin
		link_we = 1'b0;
		ch_we   = 1'b0;
		mem_re  = 1'b0;
		waddr   = addr_of(ring_q, cur_q);
		raddr   = addr_of(rsel, desc_sel);
		link_wd = chain_wlink;
		ch_wd   = prev_v_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && ring_ok) begin
					case (dfl_pkg::func_t'(func))
						dfl_pkg::FN_ALLOC, dfl_pkg::FN_CHAIN: begin
							mem_re = 1'b1;
							raddr  = addr_of(ridx_in, head_r[DW-1:0]);
						end
						dfl_pkg::FN_READ: begin
							mem_re = 1'b1;
						end
						dfl_pkg::FN_FREE: begin
							link_we = (desc_sel < len_r) && (free_r < len_r);
							waddr   = addr_of(ridx_in, desc_sel);
							link_wd = head_r;
						end
						default: ;
					endcase
				end
			end
			ST_INIT: begin
				link_we = 1'b1;
				ch_we   = 1'b1;
				waddr   = addr_of(ring_q, idx_q[DW-1:0]);
				link_wd = (idx_q == '0) ? dfl_pkg::END_MARK : LW'(idx_q - NW'(1));
				ch_wd   = 1'b0;
			end
			ST_POP: begin
				link_we = chain_q;
				ch_we   = chain_q;
				mem_re  = 1'b1;
				raddr   = addr_of(ring_q, pop_link[DW-1:0]);
			end
			ST_READ: ;
			default: ;
		endcase
	end

	// state, ring registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < RINGS; i++) begin
				head_q[i] <= dfl_pkg::END_MARK;
				free_q[i] <= '0;
				len_q[i]  <= '0;
			end
			ring_q     <= '0;
			cur_q      <= '0;
			prev_q     <= '0;
			prev_v_q   <= 1'b0;
			chain_q    <= 1'b0;
			cnt_q      <= '0;
			idx_q      <= '0;
			fwd_q      <= 1'b0;
			fwd_link_q <= '0;
			done_q     <= 1'b0;
			status_q   <= dfl_pkg::STAT_OK;
			got_q      <= dfl_pkg::END_MARK;
			lval_q     <= '0;
			lch_q      <= 1'b0;
			free_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						ring_q     <= ridx_in;
						done_q     <= 1'b1;
						status_q   <= dfl_pkg::STAT_OK;
						got_q      <= dfl_pkg::END_MARK;
						lval_q     <= '0;
						lch_q      <= 1'b0;
						free_out_q <= free_r;
						cur_q      <= head_r[DW-1:0];
						prev_v_q   <= 1'b0;
						fwd_q      <= 1'b0;
						if (!ring_ok) begin
							status_q   <= dfl_pkg::STAT_BAD;
							free_out_q <= '0;
						end else begin
							unique case (dfl_pkg::func_t'(func))
								dfl_pkg::FN_INIT: begin
									if (amt_bad) begin
										status_q <= dfl_pkg::STAT_BAD;
									end else begin
										len_q[ridx_in]  <= amount;
										free_q[ridx_in] <= amount;
										head_q[ridx_in] <= LW'(amount - NW'(1));
										cnt_q           <= amount;
										idx_q           <= '0;
										done_q          <= 1'b0;
										state_q         <= ST_INIT;
									end
								end
								dfl_pkg::FN_ALLOC: begin
									if (free_r == '0) begin
										status_q <= dfl_pkg::STAT_SHORT;
									end else if (head_r >= LW'(len_r)) begin
										free_q[ridx_in] <= '0;
										status_q        <= dfl_pkg::STAT_SHORT;
										free_out_q      <= '0;
									end else begin
										cnt_q   <= NW'(1);
										chain_q <= 1'b0;
										done_q  <= 1'b0;
										state_q <= ST_POP;
									end
								end
								dfl_pkg::FN_CHAIN: begin
									if (amount == '0) begin
										status_q <= dfl_pkg::STAT_BAD;
									end else if (amount > free_r) begin
										status_q <= dfl_pkg::STAT_SHORT;
									end else if (head_r >= LW'(len_r)) begin
										free_q[ridx_in] <= '0;
										status_q        <= dfl_pkg::STAT_SHORT;
										free_out_q      <= '0;
									end else begin
										cnt_q   <= amount;
										chain_q <= 1'b1;
										done_q  <= 1'b0;
										state_q <= ST_POP;
									end
								end
								dfl_pkg::FN_FREE: begin
									if ((desc_sel >= len_r) || (free_r >= len_r)) begin
										status_q <= dfl_pkg::STAT_BAD;
									end else begin
										head_q[ridx_in] <= LW'(desc_sel);
										free_q[ridx_in] <= free_r + NW'(1);
										free_out_q      <= free_r + NW'(1);
									end
								end
								dfl_pkg::FN_READ: begin
									if (desc_sel >= len_r) begin
										status_q <= dfl_pkg::STAT_BAD;
									end else begin
										done_q  <= 1'b0;
										state_q <= ST_READ;
									end
								end
								default: begin
									status_q <= dfl_pkg::STAT_BAD;
								end
							endcase
						end
					end
				end
				ST_INIT: begin
					idx_q <= idx_q + NW'(1);
					if (idx_q == cnt_q - NW'(1)) begin
						done_q     <= 1'b1;
						status_q   <= dfl_pkg::STAT_OK;
						free_out_q <= cnt_q;
						state_q    <= ST_IDLE;
					end
				end
				ST_POP: begin
					// pop cur_q: head follows its link, chain rewrites its link
					head_q[ring_q] <= pop_link;
					prev_q         <= cur_q;
					prev_v_q       <= 1'b1;
					cnt_q          <= cnt_q - NW'(1);
					if (cnt_q == NW'(1)) begin
						free_q[ring_q] <= pop_free;
						free_out_q     <= pop_free;
						status_q       <= dfl_pkg::STAT_OK;
						got_q          <= LW'(cur_q);
						done_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end else if (pop_link >= LW'(len_q[ring_q])) begin
						// broken list: give up, chain part stays allocated
						free_q[ring_q] <= '0;
						free_out_q     <= '0;
						status_q       <= dfl_pkg::STAT_SHORT;
						got_q          <= dfl_pkg::END_MARK;
						done_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end else begin
						free_q[ring_q] <= pop_free;
						cur_q          <= pop_link[DW-1:0];
						fwd_q          <= (pop_link[DW-1:0] == cur_q);
						fwd_link_q     <= chain_wlink;
					end
				end
				ST_READ: begin
					lval_q     <= link_rd;
					lch_q      <= ch_rd;
					status_q   <= dfl_pkg::STAT_OK;
					free_out_q <= free_q[ring_q];
					done_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	dfl_ram #(
		.WIDTH(LW),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(waddr),
		.wdata(link_wd),
		.re   (mem_re),
		.raddr(raddr),
		.rdata(link_rd)
	);

	dfl_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_chain_ram (
		.clk  (clk),
		.we   (ch_we),
		.waddr(waddr),
		.wdata(ch_wd),
		.re   (mem_re),
		.raddr(raddr),
		.rdata(ch_rd)
	);

	assign done         = done_q;
	assign status       = status_q;
	assign got_index    = got_q;
	assign link_value   = lval_q;
	assign link_chained = lch_q;
	assign free_left    = free_out_q;

endmodule

[sv/dfl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dfl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[tb/free_list_checker.sv]
// Watches the allocator's command and result ports, keeps its own copy of the per-ring
// free lists and compares every result. Depends on dfl_pkg.
`timescale 1ns / 1ps

module free_list_checker
	import dfl_pkg::*;
#(
	parameter int RINGS = RINGS_DEF,
	parameter int DESCS = DESCS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [FUNC_W-1:0] func,
	input  logic [RING_W-1:0] ring_sel,
	input  logic [DIDX_W-1:0] desc_sel,
	input  logic [AMT_W-1:0]  amount,
	input  logic              done,
	input  logic [STAT_W-1:0] status,
	input  logic [LINK_W-1:0] got_index,
	input  logic [LINK_W-1:0] link_value,
	input  logic              link_chained,
	input  logic [AMT_W-1:0]  free_left,
	output int                errors,
	output int                outstanding
);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [LINK_W-1:0] got;
		logic [LINK_W-1:0] link;
		logic              chained;
		logic [AMT_W-1:0]  left;
	} reply_t;

	logic [LINK_W-1:0] head_of [RINGS];
	logic [AMT_W-1:0]  count_of [RINGS];
	logic [AMT_W-1:0]  len_of [RINGS];
	logic [LINK_W-1:0] link_mem [RINGS*DESCS];
	logic              chain_mem [RINGS*DESCS];
	reply_t            owed_replies [$];

	function automatic int slot_of(input int r, input int d);
		return r * DESCS + d;
	endfunction

	// pop the head; a head outside the ring means a broken list
	function automatic logic [LINK_W-1:0] pop_free(input int r);
		logic [LINK_W-1:0] h;
		h = head_of[r];
		if (h >= len_of[r]) begin
			count_of[r] = '0;
			return END_MARK;
		end
		head_of[r] = link_mem[slot_of(r, int'(h))];
		count_of[r] = count_of[r] - AMT_W'(1);
		return h;
	endfunction

	function automatic void push_free(input int r, input int d);
		link_mem[slot_of(r, d)] = head_of[r];
		head_of[r] = LINK_W'(d);
		count_of[r] = count_of[r] + AMT_W'(1);
	endfunction

	function automatic reply_t run_free_list_op(input logic [FUNC_W-1:0] f, input int r,
			input int d, input int amt);
		reply_t            rep;
		logic [LINK_W-1:0] p;
		logic [LINK_W-1:0] prev;
		rep = '{status: STAT_OK, got: END_MARK, link: '0, chained: 1'b0, left: '0};
		if (r >= RINGS) begin
			rep.status = STAT_BAD;
			return rep;
		end
		case (f)
			FN_INIT: begin
				if (amt == 0 || (amt & (amt - 1)) != 0 || amt > DESCS) begin
					rep.status = STAT_BAD;
				end else begin
					len_of[r] = AMT_W'(amt);
					head_of[r] = END_MARK;
					count_of[r] = '0;
					for (int i = 0; i < amt; i++) begin
						chain_mem[slot_of(r, i)] = 1'b0;
						push_free(r, i);
					end
				end
			end
			FN_ALLOC: begin
				if (count_of[r] == 0) begin
					rep.status = STAT_SHORT;
				end else begin
					rep.got = pop_free(r);
					if (rep.got == END_MARK)
						rep.status = STAT_SHORT;
				end
			end
			FN_CHAIN: begin
				if (amt == 0) begin
					rep.status = STAT_BAD;
				end else if (amt > count_of[r]) begin
					rep.status = STAT_SHORT;
				end else begin
					// first pop ends the chain, each later one points back at the previous
					prev = END_MARK;
					for (int i = 0; i < amt; i++) begin
						p = pop_free(r);
						if (p == END_MARK) begin
							rep.status = STAT_SHORT;
							prev = END_MARK;
							break;
						end
						if (prev == END_MARK) begin
							link_mem[slot_of(r, int'(p))] = '0;
							chain_mem[slot_of(r, int'(p))] = 1'b0;
						end else begin
							link_mem[slot_of(r, int'(p))] = prev;
							chain_mem[slot_of(r, int'(p))] = 1'b1;
						end
						prev = p;
					end
					rep.got = prev;
				end
			end
			FN_FREE: begin
				if (d >= len_of[r] || count_of[r] >= len_of[r])
					rep.status = STAT_BAD;
				else
					push_free(r, d);
			end
			FN_READ: begin
				if (d >= len_of[r]) begin
					rep.status = STAT_BAD;
				end else begin
					rep.link = link_mem[slot_of(r, d)];
					rep.chained = chain_mem[slot_of(r, d)];
				end
			end
			default: rep.status = STAT_BAD;
		endcase
		rep.left = count_of[r];
		return rep;
	endfunction

	task automatic flag_mismatch(input string what, input logic [LINK_W-1:0] seen,
			input logic [LINK_W-1:0] want);
		errors++;
		if (errors <= 100)
			$display("%0t ns: %s is %h, should be %h", $realtime, what, seen, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int r = 0; r < RINGS; r++) begin
				head_of[r] = END_MARK;
				count_of[r] = '0;
				len_of[r] = '0;
			end
			owed_replies.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			// a result never belongs to the command taken at the same edge
			if (done) begin
				if (owed_replies.size() == 0) begin
					flag_mismatch("unrequested result, status", LINK_W'(status), '0);
				end else begin
					want = owed_replies.pop_front();
					if (status !== want.status)
						flag_mismatch("status", LINK_W'(status), LINK_W'(want.status));
					if (got_index !== want.got)
						flag_mismatch("got_index", got_index, want.got);
					if (link_value !== want.link)
						flag_mismatch("link_value", link_value, want.link);
					if (link_chained !== want.chained)
						flag_mismatch("link_chained", LINK_W'(link_chained),
							LINK_W'(want.chained));
					if (free_left !== want.left)
						flag_mismatch("free_left", LINK_W'(free_left), LINK_W'(want.left));
				end
			end
			if (start && !busy)
				owed_replies.push_back(run_free_list_op(func, int'(ring_sel),
					int'(desc_sel), int'(amount)));
			outstanding = owed_replies.size();
		end
	end

endmodule

[tb/tb.sv]
// Top of the allocator testbench: clock, reset, directed and random commands, verdict.
// Depends on dfl_pkg, descriptor_free_list_allocator and free_list_checker.
`timescale 1ns / 1ps

module tb;
	import dfl_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	// longest command is a full ring walk of 256 descriptors
	localparam int DRAIN_CYCLES = 300;

	// per accepted command: enough to file its result into the pool of held descriptors
	typedef struct packed {
		logic [FUNC_W-1:0] f;
		logic [RING_W-1:0] r;
		logic [15:0]       ep;
	} issued_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [FUNC_W-1:0] func = '0;
	logic [RING_W-1:0] ring_sel = '0;
	logic [DIDX_W-1:0] desc_sel = '0;
	logic [AMT_W-1:0]  amount = '0;
	logic              busy;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [LINK_W-1:0] got_index;
	logic [LINK_W-1:0] link_value;
	logic              link_chained;
	logic [AMT_W-1:0]  free_left;
	int                errors;
	int                outstanding;

	int                    cycles = 0;
	int                    idle_pct = 24;
	int                    ring_len [RINGS_DEF] = '{default: 0};
	logic [15:0]           ring_epoch [RINGS_DEF] = '{default: '0};
	issued_t               issued_q [$];
	// descriptors handed out and not yet given back: {ring, index}
	logic [RING_W+DIDX_W-1:0] held_q [$];

	descriptor_free_list_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.ring_sel     (ring_sel),
		.desc_sel     (desc_sel),
		.amount       (amount),
		.done         (done),
		.status       (status),
		.got_index    (got_index),
		.link_value   (link_value),
		.link_chained (link_chained),
		.free_left    (free_left)
	);

	free_list_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.ring_sel     (ring_sel),
		.desc_sel     (desc_sel),
		.amount       (amount),
		.done         (done),
		.status       (status),
		.got_index    (got_index),
		.link_value   (link_value),
		.link_chained (link_chained),
		.free_left    (free_left),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("descriptor_free_list_allocator: mismatch");
			$finish;
		end
	end

	// Collect allocated indices so that later frees hit descriptors really in use.
	// Results of commands from before a re-init carry a stale epoch and are dropped.
	always @(posedge clk) begin
		issued_t tag;
		if (arst_n && done && issued_q.size() > 0) begin
			tag = issued_q.pop_front();
			if (status == STAT_OK && (tag.f == FN_ALLOC || tag.f == FN_CHAIN)
					&& tag.ep == ring_epoch[tag.r])
				held_q.push_back({tag.r, got_index[DIDX_W-1:0]});
		end
		if (arst_n && start && !busy)
			issued_q.push_back('{f: func, r: ring_sel, ep: ring_epoch[ring_sel]});
	end

	// one command transfer, after a random number of idle cycles
	task automatic send_cmd(input logic [FUNC_W-1:0] f, input int r,
			input logic [DIDX_W-1:0] d, input logic [AMT_W-1:0] amt);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		if (f == FN_INIT && amt != 0 && (amt & (amt - 1'b1)) == 0 && amt <= DESCS_DEF) begin
			ring_len[r] = amt;
			ring_epoch[r]++;
			for (int j = held_q.size() - 1; j >= 0; j--)
				if (held_q[j][RING_W+DIDX_W-1:DIDX_W] == r)
					held_q.delete(j);
		end
		start <= 1'b1;
		func <= f;
		ring_sel <= RING_W'(r);
		desc_sel <= d;
		amount <= amt;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int               r;
		int               pick;
		int               k;
		int               j;
		logic [DIDX_W-1:0] d;
		int               hits [$];

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: limits of the fields and most error paths
		send_cmd(FN_ALLOC, 0, '0, '0);            // ring never set up
		send_cmd(FN_FREE, 1, '0, '0);             // free on ring with no length
		send_cmd(FN_READ, 2, '0, '0);             // read on ring with no length
		send_cmd(FN_INIT, 0, '0, '0);             // zero length
		send_cmd(FN_INIT, 0, 8'hff, 9'd3);        // not a power of two
		send_cmd(FN_INIT, 0, '0, 9'h1ff);         // above ring capacity
		send_cmd(FN_INIT, 0, '0, 9'd256);         // largest ring
		send_cmd(FN_CHAIN, 0, '0, '0);            // empty chain
		send_cmd(FN_CHAIN, 0, '0, 9'd256);        // chain takes the whole ring
		send_cmd(FN_ALLOC, 0, '0, '0);            // ring now empty
		send_cmd(FN_CHAIN, 0, '0, 9'd1);          // not enough free
		send_cmd(FN_READ, 0, 8'hff, '0);          // chain tail: link 0, not chained
		send_cmd(FN_READ, 0, 8'h00, '0);          // chain head
		send_cmd(FN_FREE, 0, 8'hff, '0);
		send_cmd(FN_INIT, 1, '0, 9'd1);           // smallest ring
		send_cmd(FN_ALLOC, 1, '0, '0);
		send_cmd(FN_FREE, 1, '0, '0);
		send_cmd(FN_FREE, 1, '0, '0);             // list already full
		send_cmd(FN_FREE, 1, 8'd1, '0);           // index past ring end
		send_cmd(FN_INIT, 3, '0, 9'd2);
		send_cmd(FN_READ, 3, '0, '0);             // list tail holds the end mark
		send_cmd(FN_CHAIN, 3, '0, 9'd3);          // one short
		for (int f = FN_READ + 1; f < 2 ** FUNC_W; f++)
			send_cmd(FUNC_W'(f), 2, 8'h5a, 9'h0a5);

		// random: mostly sound use of set-up rings, some noise
		for (int n = 0; n < 2000; n++) begin
			idle_pct = (n < 667) ? 24 : (n < 1334) ? 81 : 0;
			r = $urandom_range(RINGS_DEF - 1);
			pick = $urandom_range(99);
			if (ring_len[r] == 0 || pick < 4) begin
				// mostly short rings so walks stay cheap
				k = ($urandom_range(19) == 0) ? $urandom_range(8) : $urandom_range(5);
				send_cmd(FN_INIT, r, DIDX_W'($urandom), AMT_W'(1 << k));
			end else if (pick < 30) begin
				send_cmd(FN_ALLOC, r, DIDX_W'($urandom), AMT_W'($urandom));
			end else if (pick < 45) begin
				k = ($urandom_range(9) == 0) ? $urandom_range(ring_len[r])
					: $urandom_range(6, 1);
				send_cmd(FN_CHAIN, r, DIDX_W'($urandom), AMT_W'(k));
			end else if (pick < 75) begin
				hits.delete();
				foreach (held_q[i])
					if (held_q[i][RING_W+DIDX_W-1:DIDX_W] == r)
						hits.push_back(i);
				if (hits.size() > 0) begin
					j = hits[$urandom_range(hits.size() - 1)];
					d = held_q[j][DIDX_W-1:0];
					held_q.delete(j);
					send_cmd(FN_FREE, r, d, AMT_W'($urandom));
				end else begin
					send_cmd(FN_ALLOC, r, DIDX_W'($urandom), AMT_W'($urandom));
				end
			end else if (pick < 88) begin
				send_cmd(FN_READ, r, DIDX_W'($urandom_range(ring_len[r] - 1)),
					AMT_W'($urandom));
			end else begin
				// noise: any code, any index, any count; may double free
				send_cmd(FUNC_W'($urandom), r, DIDX_W'($urandom), AMT_W'($urandom));
			end
		end
		start <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("descriptor_free_list_allocator: match");
		else
			$display("descriptor_free_list_allocator: mismatch");
		$finish;
	end

endmodule
